// ===== sv/dpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline priority queue package
// Shared types and constants for the sorted chain of queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dpq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DL_W    = 31;
	localparam int TAG_W   = 16;
	localparam int CAT_W   = 4;
	localparam int OCC_W   = 5;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT  = 2'd0,
		KIND_EXTRACT = 2'd1,
		KIND_DELETE  = 2'd2,
		KIND_NOP     = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [DL_W-1:0]  deadline;
		logic [TAG_W-1:0] tag;
		logic [CAT_W-1:0] category;
	} entry_t;

	typedef struct packed {
		kind_t            op;
		logic [DL_W-1:0]  key;
		logic [TAG_W-1:0] tag;
		logic             en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/dpq_cell.sv =====
// ----------------------------------------------------------------------------
// Deadline priority queue cell
// Holds one task; when enabled, it may take a neighbor's task or the new one, as the operation requires.
// ----------------------------------------------------------------------------
`default_nettype none

module dpq_cell
	import dpq_pkg::*;
(
	input  wire        clk,
	input  wire cell_ctrl_t ctrl,
	input  wire entry_t     new_entry,
	input  wire        valid,
	input  wire entry_t     prev_entry,
	input  wire        prev_le,
	input  wire entry_t     next_entry,
	input  wire        match_in,
	output logic       le,
	output logic       match_out,
	output entry_t     entry
);

	entry_t entry_q;
	entry_t entry_nxt;
	logic   hit;

	always_comb begin
		hit       = valid && (entry_q.tag == ctrl.tag);
		le        = valid && (entry_q.deadline <= ctrl.key);
		match_out = match_in || hit;
		entry_nxt = entry_q;
		case (ctrl.op)
			KIND_INSERT: begin
				if (le) begin
					entry_nxt = entry_q;
				end else if (prev_le) begin
					entry_nxt = new_entry;
				end else begin
					entry_nxt = prev_entry;
				end
			end
			KIND_EXTRACT: begin
				entry_nxt = next_entry;
			end
			KIND_DELETE: begin
				if (match_out) begin
					entry_nxt = next_entry;
				end
			end
			default: begin
				entry_nxt = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			entry_q <= entry_nxt;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== sv/deadline_priority_queue.sv =====
// Each result is registered into the output register when its transaction is accepted.
// Throughput: one operation per cycle while in_stall is low; every cell updates in parallel in a single step.
// The input stalls only while a finished result waits and the output is stalled.
// Reset clears the task count and the output valid; cell contents are not cleared.
// ----------------------------------------------------------------------------
// Deadline priority queue
// Sorted chain of cells holding tasks in ascending deadline order.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_priority_queue
	import dpq_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [KIND_W-1:0] kind,
	input  wire  [DL_W-1:0]   deadline,
	input  wire  [TAG_W-1:0]  name_tag,
	input  wire  [CAT_W-1:0]  category,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [STAT_W-1:0] status,
	output logic [DL_W-1:0]   out_deadline,
	output logic [TAG_W-1:0]  out_name_tag,
	output logic [CAT_W-1:0]  out_category,
	output logic [OCC_W-1:0]  occupancy
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             out_valid_q;
	status_t          status_q;
	entry_t           out_entry_q;
	logic [OCC_W-1:0] occupancy_q;

	logic       accept;
	kind_t      op;
	logic       full;
	logic       empty;
	logic       found;
	logic       apply;
	status_t    status_nxt;
	entry_t     out_nxt;
	cell_ctrl_t ctrl;
	entry_t     new_entry;

	entry_t     entries [DEPTH];
	logic       le_vec  [DEPTH];
	logic       valid_vec [DEPTH];
	logic       match_chain [DEPTH+1];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign op       = kind_t'(kind);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign found    = match_chain[DEPTH];

	assign new_entry.deadline = deadline;
	assign new_entry.tag      = name_tag;
	assign new_entry.category = category;

	always_comb begin
		apply      = 1'b0;
		status_nxt = STAT_OK;
		out_nxt    = '0;
		count_nxt  = count_q;
		case (op)
			KIND_INSERT: begin
				if (full) begin
					status_nxt = STAT_FULL;
				end else begin
					apply     = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			KIND_EXTRACT: begin
				if (empty) begin
					status_nxt = STAT_MISS;
				end else begin
					apply     = 1'b1;
					out_nxt   = entries[0];
					count_nxt = count_q - 1'b1;
				end
			end
			KIND_DELETE: begin
				if (found) begin
					apply     = 1'b1;
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = STAT_MISS;
				end
			end
			default: begin
				apply = 1'b0;
			end
		endcase
	end

	assign ctrl.op  = op;
	assign ctrl.key = deadline;
	assign ctrl.tag = name_tag;
	assign ctrl.en  = accept && apply;

	assign match_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_l;

		assign valid_vec[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_l = 1'b1;
		end else begin : g_body
			assign prev_e = entries[i-1];
			assign prev_l = le_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_e = entries[i];
		end else begin : g_inner
			assign next_e = entries[i+1];
		end

		dpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.valid      (valid_vec[i]),
			.prev_entry (prev_e),
			.prev_le    (prev_l),
			.next_entry (next_e),
			.match_in   (match_chain[i]),
			.le         (le_vec[i]),
			.match_out  (match_chain[i+1]),
			.entry      (entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_nxt;
			out_entry_q <= out_nxt;
			occupancy_q <= OCC_W'(count_nxt);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_deadline = out_entry_q.deadline;
	assign out_name_tag = out_entry_q.tag;
	assign out_category = out_entry_q.category;
	assign occupancy    = occupancy_q;

endmodule

`default_nettype wire

// ===== tb/deadline_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// Deadline priority queue testbench
// Drives insert, extract, delete and idle operations into the queue. The
// sender works in bursts with random gaps, and the receiver stalls at random,
// on a fixed pattern, or for one long hold-off that blocks the sender. A sorted
// copy of the held tasks predicts each result, and every result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deadline_priority_queue_tb;
	import dpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 1000;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_style_t;

	typedef struct {
		status_t          st;
		logic [DL_W-1:0]  dl;
		logic [TAG_W-1:0] tag;
		logic [CAT_W-1:0] cat;
		logic [OCC_W-1:0] occ;
	} op_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] kind = KIND_NOP;
	logic [DL_W-1:0]   deadline = '0;
	logic [TAG_W-1:0]  name_tag = '0;
	logic [CAT_W-1:0]  category = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [DL_W-1:0]   out_deadline;
	logic [TAG_W-1:0]  out_name_tag;
	logic [CAT_W-1:0]  out_category;
	logic [OCC_W-1:0]  occupancy;

	entry_t       sorted_tasks[DEPTH];
	int           held_count = 0;
	op_result_t   pending_results[$];
	int           mismatches = 0;
	int           idle_cycles = 0;
	stall_style_t stall_style = STALL_NONE;
	int           hold_request = 0;
	int           hold_left = 0;
	int           pattern_phase = 0;
	bit           sender_idles = 1'b0;
	int           burst_left = 0;
	logic [TAG_W-1:0] tag_pool[8];

	deadline_priority_queue DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.deadline     (deadline),
		.name_tag     (name_tag),
		.category     (category),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_deadline (out_deadline),
		.out_name_tag (out_name_tag),
		.out_category (out_category),
		.occupancy    (occupancy)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void drop_task(int pos);
		int j;
		for (j = pos; j + 1 < held_count; j++) begin
			sorted_tasks[j] = sorted_tasks[j + 1];
		end
		held_count--;
	endfunction

	function automatic op_result_t apply_queue_op(kind_t op, logic [DL_W-1:0] dl,
			logic [TAG_W-1:0] tag, logic [CAT_W-1:0] cat);
		op_result_t r;
		int pos;
		bit hit;
		r.st = STAT_OK;
		r.dl = '0;
		r.tag = '0;
		r.cat = '0;
		hit = 1'b0;
		case (op)
			KIND_INSERT: begin
				if (held_count >= DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					pos = held_count;
					while (pos > 0 && dl < sorted_tasks[pos - 1].deadline) begin
						sorted_tasks[pos] = sorted_tasks[pos - 1];
						pos--;
					end
					sorted_tasks[pos] = '{dl, tag, cat};
					held_count++;
				end
			end
			KIND_EXTRACT: begin
				if (held_count == 0) begin
					r.st = STAT_MISS;
				end else begin
					r.dl = sorted_tasks[0].deadline;
					r.tag = sorted_tasks[0].tag;
					r.cat = sorted_tasks[0].category;
					drop_task(0);
				end
			end
			KIND_DELETE: begin
				r.st = STAT_MISS;
				for (pos = 0; pos < held_count && !hit; pos++) begin
					if (sorted_tasks[pos].tag == tag) begin
						drop_task(pos);
						r.st = STAT_OK;
						hit = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.occ = OCC_W'(held_count);
		return r;
	endfunction

	// Results are checked before the transaction of the same edge is
	// predicted, so the order of the two never depends on the scheduler.
	always @(posedge clk) begin
		op_result_t exp;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no transaction waiting", $realtime);
				end else begin
					exp = pending_results.pop_front();
					if (status !== exp.st || out_deadline !== exp.dl
							|| out_name_tag !== exp.tag || out_category !== exp.cat
							|| occupancy !== exp.occ) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: expected status %0d dl %h tag %h cat %h occ %0d,",
								" got status %0d dl %h tag %h cat %h occ %0d"}, $realtime,
								exp.st, exp.dl, exp.tag, exp.cat, exp.occ,
								status, out_deadline, out_name_tag, out_category, occupancy);
					end
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(apply_queue_op(kind_t'(kind), deadline,
					name_tag, category));
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
				STALL_PATTERN: begin
					pattern_phase = (pattern_phase + 1) % 7;
					out_stall <= (pattern_phase < 3);
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_op(kind_t op, logic [DL_W-1:0] dl, logic [TAG_W-1:0] tag,
			logic [CAT_W-1:0] cat);
		int gap;
		if (sender_idles && burst_left <= 0) begin
			burst_left = $urandom_range(1, 10);
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		kind <= op;
		deadline <= dl;
		name_tag <= tag;
		category <= cat;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [DL_W-1:0] pick_deadline();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return '0;
			1: return '1;
			2, 3, 4: return DL_W'($urandom_range(0, 15));
			default: return DL_W'($urandom());
		endcase
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag(bit from_held);
		if (from_held && held_count > 0 && $urandom_range(0, 99) < 60)
			return sorted_tasks[$urandom_range(0, held_count - 1)].tag;
		if ($urandom_range(0, 99) < 70)
			return tag_pool[$urandom_range(0, 7)];
		return TAG_W'($urandom());
	endfunction

	task automatic send_random(int insert_pct, int extract_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			send_op(KIND_NOP, pick_deadline(), pick_tag(1'b0), CAT_W'($urandom()));
		else if (roll < 3 + insert_pct)
			send_op(KIND_INSERT, pick_deadline(), pick_tag(1'b0), CAT_W'($urandom()));
		else if (roll < 3 + insert_pct + extract_pct)
			send_op(KIND_EXTRACT, pick_deadline(), pick_tag(1'b0), CAT_W'($urandom()));
		else
			send_op(KIND_DELETE, pick_deadline(), pick_tag(1'b1), CAT_W'($urandom()));
	endtask

	task automatic test_empty_ops();
		send_op(KIND_EXTRACT, '0, '0, '0);
		send_op(KIND_DELETE, '0, 16'hFFFF, '0);
		send_op(KIND_NOP, '1, '1, '1);
	endtask

	task automatic test_order_and_ties();
		send_op(KIND_INSERT, '1, 16'hFFFF, 4'hF);
		send_op(KIND_INSERT, '0, 16'h0000, 4'h0);
		send_op(KIND_INSERT, 31'd100, 16'hA5A5, 4'h1);
		send_op(KIND_INSERT, 31'd100, 16'h5A5A, 4'h2);
		send_op(KIND_INSERT, 31'd100, 16'hA5A5, 4'h3);
		send_op(KIND_EXTRACT, '0, '0, '0);
	endtask

	task automatic test_full_and_delete();
		int i;
		for (i = 0; i < 12; i++)
			send_op(KIND_INSERT, DL_W'((i % 3) * 1000), TAG_W'(16'h0100 + i), CAT_W'(i));
		send_op(KIND_INSERT, 31'd1, 16'h7777, 4'h7);
		send_op(KIND_DELETE, '0, 16'h5555, '0);
		send_op(KIND_DELETE, '0, 16'hA5A5, '0);
		send_op(KIND_NOP, '0, '0, '0);
		send_op(KIND_EXTRACT, '0, '0, '0);
	endtask

	task automatic test_random_mix();
		int phase;
		int i;
		for (phase = 0; phase < 10; phase++) begin
			sender_idles = (phase % 4 != 3);
			stall_style = stall_style_t'(phase % 3);
			for (i = 0; i < 30; i++) begin
				if (phase % 2 == 0)
					send_random(25, 45);
				else
					send_random(70, 15);
			end
		end
	endtask

	task automatic test_back_to_back();
		int i;
		sender_idles = 1'b0;
		stall_style = STALL_NONE;
		for (i = 0; i < 80; i++)
			send_random(45, 30);
	endtask

	task automatic test_pressure();
		int i;
		sender_idles = 1'b0;
		stall_style = STALL_PATTERN;
		hold_request = 150;
		for (i = 0; i < 70; i++)
			send_random(70, 15);
		sender_idles = 1'b1;
		stall_style = STALL_RANDOM;
	endtask

	initial begin
		int i;
		for (i = 0; i < 8; i++)
			tag_pool[i] = TAG_W'($urandom());
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		stall_style = STALL_RANDOM;
		sender_idles = 1'b1;
		test_empty_ops();
		test_order_and_ties();
		test_full_and_delete();
		test_random_mix();
		test_back_to_back();
		test_pressure();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
